>>> rtl/core/kpec_pkg.sv
// Package for the key press event classifier.
// Holds the phase and event codes, the register map, shared structs and the key encoder.
// No dependencies.
`timescale 1ns / 1ps

package kpec_pkg;

  localparam int KeyCount = 6;
  localparam int CodeW    = 3;
  localparam int CntW     = 8;
  localparam int AddrW    = 4;
  localparam int DataW    = 32;

  typedef enum logic [1:0] {
    RegHoldLimit    = 2'd0,
    RegRepeatPeriod = 2'd1,
    RegLongLimit    = 2'd2
  } reg_idx_e;

  localparam logic [CntW-1:0] HoldLimitRst    = 8'd200;
  localparam logic [CntW-1:0] RepeatPeriodRst = 8'd8;
  localparam logic [CntW-1:0] LongLimitRst    = 8'd100;

  typedef enum logic [2:0] {
    PhIdle     = 3'd0,
    PhDebounce = 3'd1,
    PhShort    = 3'd2,
    PhHold     = 3'd3,
    PhLong     = 3'd4,
    PhWaitUp   = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    EvNone    = 3'd0,
    EvShort   = 3'd1,
    EvRepeat  = 3'd2,
    EvShortUp = 3'd3,
    EvLong    = 3'd4,
    EvLongUp  = 3'd5
  } event_e;

  typedef struct packed {
    logic [CntW-1:0] hold_limit;
    logic [CntW-1:0] repeat_period;
    logic [CntW-1:0] long_limit;
  } cfg_t;

  typedef struct packed {
    event_e           event_res;
    logic [CodeW-1:0] key_code;
  } res_t;

  // lowest-numbered pressed key, active low lines, zero when none
  function automatic logic [CodeW-1:0] encode_keys(input logic [KeyCount-1:0] lines);
    logic [CodeW-1:0] code;
    code = '0;
    for (int i = KeyCount - 1; i >= 0; i--) begin
      if (!lines[i]) begin
        code = CodeW'(i + 1);
      end
    end
    return code;
  endfunction

endpackage

>>> rtl/core/kpec_regs.sv
// APB-style configuration registers of the key press event classifier.
// Depends on kpec_pkg.
`timescale 1ns / 1ps

module kpec_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kpec_pkg::AddrW-1:0] paddr,
  input  logic [kpec_pkg::DataW-1:0] pwdata,
  output logic [kpec_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output kpec_pkg::cfg_t             cfg_o
);
  import kpec_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx_e'(paddr[AddrW-1:2]))
        RegHoldLimit:    cfg_d.hold_limit    = pwdata[CntW-1:0];
        RegRepeatPeriod: cfg_d.repeat_period = pwdata[CntW-1:0];
        RegLongLimit:    cfg_d.long_limit    = pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[AddrW-1:2]))
      RegHoldLimit:    prdata = DataW'(cfg_q.hold_limit);
      RegRepeatPeriod: prdata = DataW'(cfg_q.repeat_period);
      RegLongLimit:    prdata = DataW'(cfg_q.long_limit);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_limit    <= HoldLimitRst;
      cfg_q.repeat_period <= RepeatPeriodRst;
      cfg_q.long_limit    <= LongLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/kpec_fsm.sv
// Debounce and press classification state machine with its hold, repeat and long counters.
// Depends on kpec_pkg; steps once per enabled scan tick.
`timescale 1ns / 1ps

module kpec_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [kpec_pkg::KeyCount-1:0] key_lines_i,
  input  kpec_pkg::cfg_t                cfg_i,
  output kpec_pkg::res_t                res_o
);
  import kpec_pkg::*;

  phase_e           phase_q, phase_d;
  logic [CodeW-1:0] last_key_q, last_key_d;
  logic [CntW-1:0]  hold_q, hold_d;
  logic [CntW-1:0]  rep_q, rep_d;
  logic [CntW-1:0]  long_q, long_d;
  logic [CodeW-1:0] now;
  logic             same;
  logic [CntW-1:0]  rep_inc;
  event_e           ev;

  assign now     = encode_keys(key_lines_i);
  assign same    = (now == last_key_q);
  assign rep_inc = rep_q + 1'b1;

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PhIdle:     if (!same) phase_d = PhDebounce;
      PhDebounce: phase_d = same ? PhShort : PhIdle;
      PhShort:    phase_d = same ? PhHold : PhIdle;
      PhHold: begin
        if (same) begin
          if (hold_q > cfg_i.hold_limit) phase_d = PhLong;
        end else begin
          phase_d = (now == '0) ? PhIdle : PhDebounce;
        end
      end
      PhLong: begin
        if (same) begin
          if (long_q > cfg_i.long_limit) phase_d = PhWaitUp;
        end else begin
          phase_d = (now == '0) ? PhIdle : PhDebounce;
        end
      end
      PhWaitUp: if (!same) phase_d = (now == '0) ? PhIdle : PhDebounce;
      default:  phase_d = PhIdle;
    endcase
  end

  // events and counters
  always_comb begin
    ev         = EvNone;
    hold_d     = hold_q;
    rep_d      = rep_q;
    long_d     = long_q;
    last_key_d = now;
    case (phase_q)
      PhIdle, PhDebounce: ;
      PhShort: if (same) ev = EvShort;
      PhHold: begin
        if (same) begin
          if (hold_q <= cfg_i.hold_limit) begin
            hold_d = hold_q + 1'b1;
            if (rep_inc >= cfg_i.repeat_period) begin
              rep_d = '0;
              ev    = EvRepeat;
            end else begin
              rep_d = rep_inc;
            end
          end else begin
            hold_d = '0;
            rep_d  = '0;
          end
        end else begin
          hold_d = '0;
          rep_d  = '0;
          ev     = EvShortUp;
        end
      end
      PhLong: begin
        if (same) begin
          if (long_q > cfg_i.long_limit) begin
            long_d = '0;
            ev     = EvLong;
          end else begin
            long_d = long_q + 1'b1;
          end
        end else begin
          long_d = '0;
          ev     = EvShortUp;
        end
      end
      PhWaitUp: if (!same) ev = EvLongUp;
      default:  last_key_d = '0;
    endcase
  end

  assign res_o.event_res = ev;
  assign res_o.key_code  = (ev == EvNone) ? '0 : last_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      last_key_q <= '0;
      hold_q     <= '0;
      rep_q      <= '0;
      long_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      last_key_q <= last_key_d;
      hold_q     <= hold_d;
      rep_q      <= rep_d;
      long_q     <= long_d;
    end
  end

endmodule

>>> rtl/core/key_press_event_classifier_unit.sv
// Top level of the key press event classifier: input beat register, state machine,
// result register and configuration port. Depends on kpec_pkg, kpec_regs and kpec_fsm.
//
//   channel  dir  handshake                 payload
//   s_axis   in   s_axis_tvalid/tready      tdata[5:0] key_lines
//   m_axis   out  m_axis_tvalid/tready      tdata[2:0] key_code, tuser[2:0] event_res
//   apb      in   psel/penable/pwrite       paddr[3:2] register, pwdata[7:0] value
//
// One beat per cycle while m_axis_tready is high; an input beat passes the input
// register, then goes through the state machine into the result register.
// Reset clears the pipeline valids and the state machine and loads register defaults.
// A stalled result holds the result register; the input register still takes a
// beat while empty, then back-pressure reaches s_axis_tready.
`timescale 1ns / 1ps

module key_press_event_classifier_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [5:0] key_lines
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // [2:0] key_code
  output logic [2:0]                 m_axis_tuser,  // [2:0] event_res
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kpec_pkg::AddrW-1:0] paddr,
  input  logic [kpec_pkg::DataW-1:0] pwdata,
  output logic [kpec_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import kpec_pkg::*;

  cfg_t                cfg;
  res_t                res;
  logic                in_vld_q, in_vld_d;
  logic [KeyCount-1:0] in_keys_q;
  logic                out_vld_q, out_vld_d;
  res_t                out_q;
  logic                advance;
  logic                in_take;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign in_vld_d  = in_take || (in_vld_q && !advance);
  assign out_vld_d = advance || (out_vld_q && !m_axis_tready);

  kpec_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kpec_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .key_lines_i (in_keys_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_keys_q <= s_axis_tdata[KeyCount-1:0];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(8 - CodeW){1'b0}}, out_q.key_code};
  assign m_axis_tuser  = out_q.event_res;

`ifndef SYNTH
  a_no_key_without_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == EvNone)) |-> (m_axis_tdata == '0))
    else $error("key code reported without an event");

  a_event_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= EvLongUp))
    else $error("event code out of range");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while both stages are full");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("result register not filled after advance");
`endif

endmodule
